FILE: hw/rtl/lrhd_pkg.sv
// Types and constants shared by the log record header deframer modules.
package lrhd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [31:0] record_offset;
        logic [7:0]  record_type;
        logic [31:0] record_time;
        logic [15:0] payload_length;
    } t_out_item;

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    localparam logic [2:0]  HEADER_LAST = 3'd6;
    localparam logic [2:0]  POS_TYPE    = 3'd0;
    localparam logic [2:0]  POS_TIME_0  = 3'd1;
    localparam logic [2:0]  POS_TIME_1  = 3'd2;
    localparam logic [2:0]  POS_TIME_2  = 3'd3;
    localparam logic [2:0]  POS_TIME_3  = 3'd4;
    localparam logic [2:0]  POS_SIZE_0  = 3'd5;
    localparam logic [2:0]  POS_SIZE_1  = 3'd6;
    localparam logic [16:0] CHECKSUM_BYTES = 17'd1;

    localparam logic [7:0] SEPARATOR_RESET = 8'd30;
    localparam int         PADDR_BITS      = 3;
    localparam logic       REG_SEPARATOR   = 1'b0;

endpackage

FILE: hw/rtl/lrhd_core.sv
// Record framing state: separator hunt, header collection and payload skip.
module lrhd_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lrhd_pkg::t_in_item  i_item,
    input  logic [7:0]          i_separator,
    output logic                o_emit,
    output lrhd_pkg::t_out_item o_result
);

    logic [1:0]             r_phase, n_phase;
    logic [2:0]             r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [7:0]             r_type, n_type;
    logic [31:0]            r_time, n_time;
    logic [15:0]            r_size, n_size;
    logic [16:0]            r_skip, n_skip;
    logic [63:0]            w_start_ext;
    logic [7:0]             w_byte;

    assign w_byte      = i_item.data_byte;
    assign o_emit      = (r_phase == lrhd_pkg::PH_HEADER) && (r_pos >= lrhd_pkg::HEADER_LAST);
    assign w_start_ext = 64'(r_start);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_start  = r_start;
        n_type   = r_type;
        n_time   = r_time;
        n_size   = r_size;
        n_skip   = r_skip;
        n_offset = (r_offset != '1) ? r_offset + 1'b1 : r_offset;
        case (r_phase)
            lrhd_pkg::PH_HEADER: begin
                case (r_pos)
                    lrhd_pkg::POS_TYPE:   n_type = w_byte;
                    lrhd_pkg::POS_TIME_0: n_time = r_time | {24'd0, w_byte};
                    lrhd_pkg::POS_TIME_1: n_time = r_time | {16'd0, w_byte, 8'd0};
                    lrhd_pkg::POS_TIME_2: n_time = r_time | {8'd0, w_byte, 16'd0};
                    lrhd_pkg::POS_TIME_3: n_time = r_time | {w_byte, 24'd0};
                    lrhd_pkg::POS_SIZE_0: n_size = r_size | {8'd0, w_byte};
                    lrhd_pkg::POS_SIZE_1: n_size = r_size | {w_byte, 8'd0};
                    default: ;
                endcase
                if (r_pos >= lrhd_pkg::HEADER_LAST) begin
                    n_skip  = 17'(n_size) + lrhd_pkg::CHECKSUM_BYTES;
                    n_pos   = lrhd_pkg::POS_TYPE;
                    n_phase = lrhd_pkg::PH_SKIP;
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            lrhd_pkg::PH_SKIP: begin
                if (r_skip != 17'd0) begin
                    n_skip = r_skip - 17'd1;
                end
                if (n_skip == 17'd0) begin
                    n_phase = lrhd_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = lrhd_pkg::PH_HUNT;
                if (w_byte == i_separator) begin
                    n_start = r_offset;
                    n_type  = 8'd0;
                    n_time  = 32'd0;
                    n_size  = 16'd0;
                    n_pos   = lrhd_pkg::POS_TYPE;
                    n_phase = lrhd_pkg::PH_HEADER;
                end
            end
        endcase

        o_result.record_offset  = (w_start_ext > 64'h0000_0000_FFFF_FFFF) ?
                                  32'hFFFF_FFFF : w_start_ext[31:0];
        o_result.record_type    = n_type;
        o_result.record_time    = n_time;
        o_result.payload_length = n_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.end_of_file)) begin
            r_phase  <= lrhd_pkg::PH_HUNT;
            r_pos    <= lrhd_pkg::POS_TYPE;
            r_offset <= '0;
            r_start  <= '0;
            r_type   <= 8'd0;
            r_time   <= 32'd0;
            r_size   <= 16'd0;
            r_skip   <= 17'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_type   <= n_type;
            r_time   <= n_time;
            r_size   <= n_size;
            r_skip   <= n_skip;
        end
    end

endmodule

FILE: hw/rtl/log_record_header_deframer_unit.sv
// Top level of the log record header deframer: input register, framing core, result register.
// A byte that completes a header is held in the input register, and its result is captured in the result register.
// Throughput: one byte per cycle while the result side takes each result as it is offered.
// The input register and the result register let a new byte enter while a result waits.
// Reset clears the framing state and the valid flags of both registers and sets the separator to 30.
// An end-of-file byte returns the framing state to its reset value; the separator is kept.
module log_record_header_deframer_unit #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lrhd_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lrhd_pkg::t_out_item                 o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrhd_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic                w_sep;
    logic [7:0]          r_separator;
    logic                r_in_valid;
    lrhd_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    lrhd_pkg::t_out_item r_out_item;
    logic                w_emit;
    logic                w_out_free;
    logic                w_step;
    lrhd_pkg::t_out_item w_result;

    assign w_sep  = (paddr[lrhd_pkg::PADDR_BITS-1] == lrhd_pkg::REG_SEPARATOR);
    assign pready = 1'b1;
    assign prdata = w_sep ? {24'd0, r_separator} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= lrhd_pkg::SEPARATOR_RESET;
        end else if (psel && penable && pwrite && w_sep) begin
            r_separator <= pwdata[7:0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && (!w_emit || w_out_free);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    lrhd_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in_item),
        .i_separator (r_separator),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
